// ----- hdl/bsf_pkg.sv -----
// Shared types and constants for the byte-stuffing framer.
// No dependencies; imported by every module of the block.
`default_nettype none

package bsf_pkg;

  localparam logic [7:0] StartDelim = 8'h5B;  // '['
  localparam logic [7:0] EndDelim   = 8'h5D;  // ']'
  localparam logic [7:0] EscA       = 8'h5A;
  localparam logic [7:0] EscC       = 8'h5C;
  localparam logic [7:0] CodeSelf   = 8'h00;  // follows 0x5A / 0x5C
  localparam logic [7:0] CodeDec    = 8'h01;  // follows decremented 0x5B / 0x5D

  localparam int unsigned MaxBytes      = 4;
  localparam int unsigned QueueDepthDef = 4;

  // One classified input beat: up to four output bytes in emit order.
  typedef struct packed {
    logic [MaxBytes-1:0][7:0] bytes;
    logic [1:0]               last_idx;  // index of the final byte
    logic                     has_end;   // final byte is the end delimiter
  } bsf_desc_t;

endpackage

`default_nettype wire

// ----- hdl/bsf_front.sv -----
// Front end: classifies one input beat into an output-byte descriptor.
// Depends on bsf_pkg.
`default_nettype none

module bsf_front (
  input  logic [7:0]        data_byte_i,
  input  logic              first_of_packet_i,
  input  logic              last_of_packet_i,
  output bsf_pkg::bsf_desc_t desc_o
);
  import bsf_pkg::*;

  logic       esc_self;
  logic       esc_dec;
  logic       two;
  logic [1:0] pos;

  always_comb begin
    esc_self = (data_byte_i == EscA) || (data_byte_i == EscC);
    esc_dec  = (data_byte_i == StartDelim) || (data_byte_i == EndDelim);
    two      = esc_self || esc_dec;
    pos      = {1'b0, first_of_packet_i};

    desc_o = '0;
    if (first_of_packet_i) begin
      desc_o.bytes[0] = StartDelim;
    end
    desc_o.bytes[pos] = esc_dec ? (data_byte_i - 8'd1) : data_byte_i;
    if (two) begin
      desc_o.bytes[pos + 2'd1] = esc_self ? CodeSelf : CodeDec;
    end
    if (last_of_packet_i) begin
      desc_o.bytes[pos + {1'b0, two} + 2'd1] = EndDelim;
    end
    desc_o.last_idx = pos + {1'b0, two} + {1'b0, last_of_packet_i};
    desc_o.has_end  = last_of_packet_i;
  end

endmodule

`default_nettype wire

// ----- hdl/bsf_queue.sv -----
// Short descriptor queue between front and back end, built from flops.
// Depends on bsf_pkg.
`default_nettype none

module bsf_queue #(
  parameter int unsigned Depth = bsf_pkg::QueueDepthDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               wr_i,
  input  bsf_pkg::bsf_desc_t wr_desc_i,
  output logic               full_o,
  input  logic               rd_i,
  output logic               valid_o,
  output bsf_pkg::bsf_desc_t rd_desc_o
);
  import bsf_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  bsf_desc_t          mem_q [Depth];
  logic [PtrW-1:0]    wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]    rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]    cnt_q, cnt_d;
  logic               do_wr, do_rd;

  assign full_o    = (cnt_q == CntW'(Depth));
  assign valid_o   = (cnt_q != '0);
  assign rd_desc_o = mem_q[rd_ptr_q];
  assign do_wr     = wr_i && !full_o;
  assign do_rd     = rd_i && valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_wr) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_rd) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_wr && !do_rd) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_rd && !do_wr) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wr_ptr_q] <= wr_desc_i;
    end
  end

endmodule

`default_nettype wire

// ----- hdl/bsf_back.sv -----
// Back end: walks one descriptor into the output register a byte per cycle unless a held output byte is not popped.
// Depends on bsf_pkg.
`default_nettype none

module bsf_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               desc_valid_i,
  input  bsf_pkg::bsf_desc_t desc_i,
  output logic               desc_pop_o,
  output logic               empty,
  input  logic               pop,
  output logic [7:0]         out_byte_o,
  output logic               run_end_o,
  output logic               packet_end_o
);
  import bsf_pkg::*;

  logic       out_vld_q;
  logic [7:0] out_byte_q;
  logic       run_end_q, packet_end_q;
  logic [1:0] idx_q, idx_d;
  logic       load, at_last;

  // Output slot frees when empty or being drained this cycle.
  assign load       = desc_valid_i && (!out_vld_q || pop);
  assign at_last    = (idx_q == desc_i.last_idx);
  assign desc_pop_o = load && at_last;
  assign idx_d      = at_last ? 2'd0 : idx_q + 2'd1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
      idx_q     <= '0;
    end else begin
      if (load) begin
        out_vld_q <= 1'b1;
        idx_q     <= idx_d;
      end else if (pop) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_byte_q   <= desc_i.bytes[idx_q];
      run_end_q    <= at_last;
      packet_end_q <= at_last && desc_i.has_end;
    end
  end

  assign empty        = !out_vld_q;
  assign out_byte_o   = out_byte_q;
  assign run_end_o    = run_end_q;
  assign packet_end_o = packet_end_q;

endmodule

`default_nettype wire

// ----- hdl/byte_stuffing_framer.sv -----
// Top level of the byte-stuffing packet framer.
// Depends on bsf_pkg, bsf_front, bsf_queue and bsf_back.
// Usage:
//   Input side is a queue write port: present data_byte_i with the
//   first/last flags and raise push; the beat is taken at a clock edge
//   where push is high and full is low.
//   Output side is a queue read port: while empty is low, out_byte_o,
//   run_end_o and packet_end_o show the oldest framed byte; pop takes it.
//   Each input beat yields 1 to 4 output bytes: optional '[' start
//   delimiter, the stuffed byte (0x5A/0x5C -> byte,0x00; 0x5B/0x5D ->
//   byte-1,0x01), optional ']' end delimiter. run_end_o marks the last
//   byte of each beat, packet_end_o marks the end delimiter.
//   The first output byte of a beat goes through the descriptor queue and
//   then the output register when the back end is idle.
//   Throughput: the back end emits one byte per cycle while the receiver
//   keeps popping, so a beat takes one output slot per byte. Input beats keep
//   being taken back to back while the descriptor queue (QueueDepth
//   entries) has room.
//   Reset empties the queue and the output register. A stalled receiver
//   holds the output byte; the queue fills and then full rises.
`default_nettype none

module byte_stuffing_framer #(
  parameter int unsigned QueueDepth = bsf_pkg::QueueDepthDef
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push,
  output logic       full,
  input  logic [7:0] data_byte_i,
  input  logic       first_of_packet_i,
  input  logic       last_of_packet_i,
  output logic       empty,
  input  logic       pop,
  output logic [7:0] out_byte_o,
  output logic       run_end_o,
  output logic       packet_end_o
);
  import bsf_pkg::*;

  bsf_desc_t front_desc;
  bsf_desc_t q_desc;
  logic      q_valid;
  logic      q_pop;

  bsf_front u_front (
    .data_byte_i      (data_byte_i),
    .first_of_packet_i(first_of_packet_i),
    .last_of_packet_i (last_of_packet_i),
    .desc_o           (front_desc)
  );

  bsf_queue #(
    .Depth(QueueDepth)
  ) u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .wr_i     (push),
    .wr_desc_i(front_desc),
    .full_o   (full),
    .rd_i     (q_pop),
    .valid_o  (q_valid),
    .rd_desc_o(q_desc)
  );

  bsf_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .desc_valid_i(q_valid),
    .desc_i      (q_desc),
    .desc_pop_o  (q_pop),
    .empty       (empty),
    .pop         (pop),
    .out_byte_o  (out_byte_o),
    .run_end_o   (run_end_o),
    .packet_end_o(packet_end_o)
  );

endmodule

`default_nettype wire
